// File: rtl/lru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement - shared constants
// Frame count, index and rank widths, field widths.
// ----------------------------------------------------------------------------
package lru_pkg;

    localparam int MAX_FRAMES = 8;
    localparam int FRAME_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RANK_W     = FRAME_W;
    localparam int PAGE_W     = 8;
    localparam int CFG_W      = 4;
    localparam int FIDX_W     = 3;
    localparam int FAULT_W    = 32;

    localparam logic [RANK_W-1:0]  RANK_MAX       = RANK_W'(MAX_FRAMES - 1);
    localparam logic [CFG_W-1:0]   CFG_RESET      = CFG_W'(8);
    localparam logic [FAULT_W-1:0] FAULT_SATURATE = '1;

    typedef logic [PAGE_W-1:0]  t_page;
    typedef logic [RANK_W-1:0]  t_rank;
    typedef logic [FRAME_W-1:0] t_frame;

endpackage

// File: rtl/lru_page_replacement_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement
// Small fully associative frame set with recency ranks; one page reference
// in, one hit/fault report out.
//
//   channel  direction  handshake              word
//   in       input      i_valid / o_stall      i_page
//   out      output     o_valid / i_stall      hit, frame, eviction, faults
//   cfg      input      i_cfg_valid / ready    i_cfg_data (frames in use)
//
// One reference per cycle unless the result stalls; o_valid is registered.
// The input register feeds a single pass of tag compare, free/LRU select
// and rank update, all parallel over the frame set, into the result register.
// Reset (synchronous, active low) empties all frames and sets 8 frames in use.
// A stalled result holds the pass, and the input stalls only while both
// registers are full and the result is stalled.
// ----------------------------------------------------------------------------
module lru_page_replacement_top
    import lru_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [PAGE_W-1:0]   i_page,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_hit,
    output logic [FIDX_W-1:0]   o_frame_index,
    output logic                o_evicted_valid,
    output logic [PAGE_W-1:0]   o_evicted_page,
    output logic [FAULT_W-1:0]  o_fault_count,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    logic [CFG_W-1:0]       r_cfg;
    logic                   r_in_valid;
    t_page                  r_page;
    logic                   r_out_valid;
    logic                   r_hit;
    logic [FIDX_W-1:0]      r_frame_index;
    logic                   r_ev_valid;
    t_page                  r_ev_page;
    logic [FAULT_W-1:0]     r_faults;
    t_page                  r_frame_page [MAX_FRAMES];
    logic [MAX_FRAMES-1:0]  r_frame_valid;
    t_rank                  r_rank       [MAX_FRAMES];

    logic [MAX_FRAMES-1:0]  act;
    logic [MAX_FRAMES-1:0]  match;
    logic [MAX_FRAMES-1:0]  free;
    logic [MAX_FRAMES-1:0]  lru_cand;
    logic [MAX_FRAMES-1:0]  age;
    logic                   hit_any;
    logic                   free_any;
    t_frame                 hit_idx;
    t_frame                 free_idx;
    t_frame                 lru_idx;
    t_frame                 target;
    t_rank                  limit;
    logic                   proc;

    assign proc        = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall     = r_in_valid && !proc;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        act      = '0;
        match    = '0;
        free     = '0;
        lru_cand = '0;
        age      = '0;
        hit_idx  = '0;
        free_idx = '0;
        lru_idx  = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            act[i]   = (i == 0) || (32'(r_cfg) > 32'(i));
            match[i] = act[i] && r_frame_valid[i] && (r_frame_page[i] == r_page);
            free[i]  = act[i] && !r_frame_valid[i];
        end
        for (int i = 0; i < MAX_FRAMES; i++) begin
            lru_cand[i] = act[i];
            for (int j = 0; j < MAX_FRAMES; j++) begin
                if (act[j] && (j < i) && (r_rank[j] >= r_rank[i])) begin
                    lru_cand[i] = 1'b0;
                end
                if (act[j] && (j > i) && (r_rank[j] > r_rank[i])) begin
                    lru_cand[i] = 1'b0;
                end
            end
        end
        for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = FRAME_W'(i);
            end
            if (free[i]) begin
                free_idx = FRAME_W'(i);
            end
            if (lru_cand[i]) begin
                lru_idx = FRAME_W'(i);
            end
        end
        hit_any  = |match;
        free_any = |free;
        target   = hit_any ? hit_idx : (free_any ? free_idx : lru_idx);
        limit    = r_rank[hit_idx];
        for (int i = 0; i < MAX_FRAMES; i++) begin
            age[i] = act[i] && r_frame_valid[i] && (r_rank[i] < RANK_MAX)
                     && (!hit_any || (r_rank[i] < limit));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg         <= CFG_RESET;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_faults      <= '0;
            r_frame_valid <= '0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (proc) begin
                for (int i = 0; i < MAX_FRAMES; i++) begin
                    if (FRAME_W'(i) == target) begin
                        r_rank[i] <= '0;
                    end else if (age[i]) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
                if (!hit_any) begin
                    r_frame_valid[target] <= 1'b1;
                    if (r_faults != FAULT_SATURATE) begin
                        r_faults <= r_faults + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_page <= i_page;
        end
        if (proc) begin
            r_hit         <= hit_any;
            r_frame_index <= FIDX_W'(target);
            r_ev_valid    <= !hit_any && !free_any;
            r_ev_page     <= (!hit_any && !free_any) ? r_frame_page[target] : '0;
            if (!hit_any) begin
                r_frame_page[target] <= r_page;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_hit;
    assign o_frame_index   = r_frame_index;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_fault_count   = r_faults;

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_evicted_valid))
        else $error("hit reported with an eviction");

    a_no_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_evicted_valid) |-> (o_evicted_page == '0))
        else $error("evicted page not zero without eviction");

    a_hit_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && hit_any) |=> (r_faults == $past(r_faults)))
        else $error("fault counted on a hit");

    a_target_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> (r_frame_valid[$past(target)] && (r_rank[$past(target)] == '0)))
        else $error("touched frame not valid and most recent");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled with room to advance");

endmodule
